FILE: rtl/core/hnm_pkg.sv
// Package of shared types, constants and scale tables for the harmony note mapper.
package hnm_pkg;

    localparam int NOTE_W      = 7;
    localparam int CONF_W      = 10;
    localparam int KEY_W       = 4;
    localparam int INTERVAL_W  = 5;
    localparam int KIND_W      = 2;
    localparam int TARGET_W    = 9;
    localparam int SHIFT_W     = 6;
    localparam int GATE_W      = 7;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam int SEMIS_PER_OCTAVE = 12;
    localparam int DIATONIC_SIZE    = 7;

    localparam logic [GATE_W-1:0] GATE_FALL = 7'd2;
    localparam logic [GATE_W-1:0] GATE_RISE = 7'd8;
    localparam logic [GATE_W-1:0] GATE_FULL = 7'd100;

    localparam logic [CONF_W-1:0] THRESHOLD_RESET = 10'd512;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HARMONY_MODE         = 3'd0,
        REG_SCALE_KIND           = 3'd1,
        REG_KEY_ROOT             = 3'd2,
        REG_VOICE_ONE_INTERVAL   = 3'd3,
        REG_VOICE_TWO_INTERVAL   = 3'd4,
        REG_CONFIDENCE_THRESHOLD = 3'd5
    } t_reg_index;

    localparam logic MODE_DIATONIC = 1'b0;
    localparam logic MODE_FIXED    = 1'b1;

    localparam logic [KIND_W-1:0] KIND_CHROMATIC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MAJOR     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MINOR     = 2'd2;

    // Settings shared by both voices.
    typedef struct packed {
        logic              mode;
        logic [KIND_W-1:0] scale_kind;
        logic [KEY_W-1:0]  key_root;
    } t_voice_cfg;

    localparam logic [3:0] MAJOR_DEG [DIATONIC_SIZE] = '{
        4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11
    };
    localparam logic [3:0] MINOR_DEG [DIATONIC_SIZE] = '{
        4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10
    };

    // Nearest degree index for each pitch class; ties go to the lower index.
    localparam logic [2:0] MAJOR_SNAP [SEMIS_PER_OCTAVE] = '{
        3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6
    };
    localparam logic [2:0] MINOR_SNAP [SEMIS_PER_OCTAVE] = '{
        3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6
    };

endpackage

FILE: rtl/core/hnm_if.sv
// Stream and configuration channel interfaces of the harmony note mapper.
interface hnm_note_if;
    logic                             valid;
    logic                             ready;
    logic [hnm_pkg::NOTE_W-1:0]       source_note;
    logic                             voiced;
    logic [hnm_pkg::CONF_W-1:0]       confidence;

    modport source (output valid, output source_note, output voiced, output confidence,
                    input ready);
    modport sink   (input valid, input source_note, input voiced, input confidence,
                    output ready);
endinterface

interface hnm_result_if;
    logic                                valid;
    logic                                ready;
    logic                                active;
    logic signed [hnm_pkg::TARGET_W-1:0] voice_one_target;
    logic signed [hnm_pkg::TARGET_W-1:0] voice_two_target;
    logic signed [hnm_pkg::SHIFT_W-1:0]  voice_one_shift;
    logic signed [hnm_pkg::SHIFT_W-1:0]  voice_two_shift;
    logic [hnm_pkg::GATE_W-1:0]          gate_level;

    modport source (output valid, output active, output voice_one_target,
                    output voice_two_target, output voice_one_shift,
                    output voice_two_shift, output gate_level, input ready);
    modport sink   (input valid, input active, input voice_one_target,
                    input voice_two_target, input voice_one_shift,
                    input voice_two_shift, input gate_level, output ready);
endinterface

interface hnm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [hnm_pkg::CFG_INDEX_W-1:0]     index;
    logic [hnm_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/hnm_voice_calc.sv
// Target note and shift of one harmony voice, fixed or diatonic.
module hnm_voice_calc (
    input  hnm_pkg::t_voice_cfg                 i_cfg,
    input  logic [hnm_pkg::NOTE_W-1:0]          i_source_note,
    input  logic signed [hnm_pkg::INTERVAL_W-1:0] i_interval,
    output logic signed [hnm_pkg::TARGET_W-1:0] o_target,
    output logic signed [hnm_pkg::SHIFT_W-1:0]  o_shift
);

    logic signed [8:0] rel;
    logic signed [4:0] oct;
    logic signed [8:0] oct_base;
    logic [3:0]        pc;
    logic              is_major;
    logic              is_minor;
    logic [3:0]        best;
    logic signed [5:0] tdeg;
    logic signed [4:0] step_oct;
    logic signed [5:0] step_base;
    logic [3:0]        wrapped;
    logic [3:0]        degree;
    logic signed [4:0] toct;
    logic signed [hnm_pkg::TARGET_W-1:0] diatonic_target;

    assign is_major = (i_cfg.scale_kind == hnm_pkg::KIND_MAJOR);
    assign is_minor = (i_cfg.scale_kind == hnm_pkg::KIND_MINOR);

    // Octave and pitch class relative to the key tonic (floor division by 12).
    assign rel = 9'(int'(i_source_note) - int'(i_cfg.key_root));

    always_comb begin
        oct      = -5'sd2;
        oct_base = -9'sd24;
        for (int k = -1; k <= 10; k++) begin
            if (int'(rel) >= k * hnm_pkg::SEMIS_PER_OCTAVE) begin
                oct      = 5'(k);
                oct_base = 9'(k * hnm_pkg::SEMIS_PER_OCTAVE);
            end
        end
    end

    assign pc = 4'(rel - oct_base);

    always_comb begin
        if (is_major) begin
            best = {1'b0, hnm_pkg::MAJOR_SNAP[pc]};
        end else if (is_minor) begin
            best = {1'b0, hnm_pkg::MINOR_SNAP[pc]};
        end else begin
            best = pc;
        end
    end

    assign tdeg = 6'(int'(best) + int'(i_interval));

    // Wrap the stepped degree into the scale, carrying whole octaves. Only a
    // seven-degree scale can step below minus two octaves.
    always_comb begin
        step_oct  = -5'sd3;
        step_base = 6'(-3 * hnm_pkg::DIATONIC_SIZE);
        for (int k = -2; k <= 3; k++) begin
            if (is_major || is_minor) begin
                if (int'(tdeg) >= k * hnm_pkg::DIATONIC_SIZE) begin
                    step_oct  = 5'(k);
                    step_base = 6'(k * hnm_pkg::DIATONIC_SIZE);
                end
            end else begin
                if (int'(tdeg) >= k * hnm_pkg::SEMIS_PER_OCTAVE) begin
                    step_oct  = 5'(k);
                    step_base = 6'(k * hnm_pkg::SEMIS_PER_OCTAVE);
                end
            end
        end
    end

    assign wrapped = 4'(tdeg - step_base);

    always_comb begin
        if (is_major) begin
            degree = hnm_pkg::MAJOR_DEG[wrapped[2:0]];
        end else if (is_minor) begin
            degree = hnm_pkg::MINOR_DEG[wrapped[2:0]];
        end else begin
            degree = wrapped;
        end
    end

    assign toct = oct + step_oct;

    assign diatonic_target = hnm_pkg::TARGET_W'(int'(i_cfg.key_root)
                           + int'(toct) * hnm_pkg::SEMIS_PER_OCTAVE + int'(degree));

    always_comb begin
        if (i_cfg.mode == hnm_pkg::MODE_FIXED) begin
            o_target = hnm_pkg::TARGET_W'(int'(i_source_note) + int'(i_interval));
        end else begin
            o_target = diatonic_target;
        end
        o_shift = hnm_pkg::SHIFT_W'(int'(o_target) - int'(i_source_note));
    end

endmodule

FILE: rtl/core/harmony_note_mapper_core.sv
// Top level of the harmony note mapper: pitch analysis in, two harmony voice targets out.
//
// Each transfer on the note channel carries one pitch-analysis result and yields exactly
// one transfer on the result channel, in order. An item passes through two registers, an
// input register and a result register: it enters the input register at its own transfer
// edge and moves to the result register when that register advances; the two-stage
// pipeline takes one item in every cycle unless the result channel stalls, and the result
// channel's ready passes back combinationally to the note channel's ready. Between the two
// registers lies one pass of logic: the confidence gate, the voice gate update, and for
// each voice either a plain semitone add (fixed mode) or a snap to the nearest scale
// degree followed by a step in degrees with octave wrap (diatonic mode). An unvoiced item,
// or one whose confidence is below the threshold, gives an inactive result with zero
// targets and shifts, and lowers the gate by two hundredths; an accepted pitch raises it
// by eight, up to full level. Configuration writes are always ready and are meant to
// arrive while no item is in flight; writes to an index beyond the register list are
// ignored.
module harmony_note_mapper_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    hnm_note_if.sink       i_note,
    hnm_result_if.source   o_result,
    hnm_cfg_if.sink        i_cfg
);

    // Configuration registers.
    logic                                  r_harmony_mode;
    logic [hnm_pkg::KIND_W-1:0]            r_scale_kind;
    logic [hnm_pkg::KEY_W-1:0]             r_key_root;
    logic signed [hnm_pkg::INTERVAL_W-1:0] r_voice_one_interval;
    logic signed [hnm_pkg::INTERVAL_W-1:0] r_voice_two_interval;
    logic [hnm_pkg::CONF_W-1:0]            r_confidence_threshold;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_harmony_mode         <= hnm_pkg::MODE_DIATONIC;
            r_scale_kind           <= hnm_pkg::KIND_CHROMATIC;
            r_key_root             <= '0;
            r_voice_one_interval   <= '0;
            r_voice_two_interval   <= '0;
            r_confidence_threshold <= hnm_pkg::THRESHOLD_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                hnm_pkg::REG_HARMONY_MODE: begin
                    r_harmony_mode <= i_cfg.data[0];
                end
                hnm_pkg::REG_SCALE_KIND: begin
                    r_scale_kind <= i_cfg.data[hnm_pkg::KIND_W-1:0];
                end
                hnm_pkg::REG_KEY_ROOT: begin
                    r_key_root <= i_cfg.data[hnm_pkg::KEY_W-1:0];
                end
                hnm_pkg::REG_VOICE_ONE_INTERVAL: begin
                    r_voice_one_interval <= signed'(i_cfg.data[hnm_pkg::INTERVAL_W-1:0]);
                end
                hnm_pkg::REG_VOICE_TWO_INTERVAL: begin
                    r_voice_two_interval <= signed'(i_cfg.data[hnm_pkg::INTERVAL_W-1:0]);
                end
                hnm_pkg::REG_CONFIDENCE_THRESHOLD: begin
                    r_confidence_threshold <= i_cfg.data[hnm_pkg::CONF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow: the result register advances when empty or when its result is
    // taken; the input register advances along with it or whenever it is empty.
    logic r_in_valid;
    logic r_out_valid;
    logic advance;

    assign advance      = !r_out_valid || o_result.ready;
    assign i_note.ready = !r_in_valid || advance;

    logic [hnm_pkg::NOTE_W-1:0] r_source_note;
    logic                       r_voiced;
    logic [hnm_pkg::CONF_W-1:0] r_confidence;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_note.ready) begin
            r_in_valid <= i_note.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_note.valid && i_note.ready) begin
            r_source_note <= i_note.source_note;
            r_voiced      <= i_note.voiced;
            r_confidence  <= i_note.confidence;
        end
    end

    // Voice computation for both voices from the registered item.
    hnm_pkg::t_voice_cfg voice_cfg;

    assign voice_cfg.mode       = r_harmony_mode;
    assign voice_cfg.scale_kind = r_scale_kind;
    assign voice_cfg.key_root   = r_key_root;

    logic signed [hnm_pkg::TARGET_W-1:0] one_target;
    logic signed [hnm_pkg::TARGET_W-1:0] two_target;
    logic signed [hnm_pkg::SHIFT_W-1:0]  one_shift;
    logic signed [hnm_pkg::SHIFT_W-1:0]  two_shift;

    hnm_voice_calc u_voice_one (
        .i_cfg         (voice_cfg),
        .i_source_note (r_source_note),
        .i_interval    (r_voice_one_interval),
        .o_target      (one_target),
        .o_shift       (one_shift)
    );

    hnm_voice_calc u_voice_two (
        .i_cfg         (voice_cfg),
        .i_source_note (r_source_note),
        .i_interval    (r_voice_two_interval),
        .o_target      (two_target),
        .o_shift       (two_shift)
    );

    // Voice gate: falls on a rejected pitch, rises on an accepted one, both clamped.
    logic                        pitch_ok;
    logic [hnm_pkg::GATE_W-1:0]  r_gate;
    logic [hnm_pkg::GATE_W-1:0]  n_gate;
    logic [hnm_pkg::GATE_W:0]    gate_raised;

    assign pitch_ok    = r_voiced && (r_confidence >= r_confidence_threshold);
    assign gate_raised = {1'b0, r_gate} + {1'b0, hnm_pkg::GATE_RISE};

    always_comb begin
        if (pitch_ok) begin
            if (gate_raised > {1'b0, hnm_pkg::GATE_FULL}) begin
                n_gate = hnm_pkg::GATE_FULL;
            end else begin
                n_gate = gate_raised[hnm_pkg::GATE_W-1:0];
            end
        end else begin
            if (r_gate > hnm_pkg::GATE_FALL) begin
                n_gate = r_gate - hnm_pkg::GATE_FALL;
            end else begin
                n_gate = '0;
            end
        end
    end

    logic take_item;

    assign take_item = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate <= '0;
        end else if (take_item) begin
            r_gate <= n_gate;
        end
    end

    // Result register.
    logic                                r_active;
    logic signed [hnm_pkg::TARGET_W-1:0] r_one_target;
    logic signed [hnm_pkg::TARGET_W-1:0] r_two_target;
    logic signed [hnm_pkg::SHIFT_W-1:0]  r_one_shift;
    logic signed [hnm_pkg::SHIFT_W-1:0]  r_two_shift;
    logic [hnm_pkg::GATE_W-1:0]          r_gate_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_item) begin
            r_active     <= pitch_ok;
            r_one_target <= pitch_ok ? one_target : '0;
            r_two_target <= pitch_ok ? two_target : '0;
            r_one_shift  <= pitch_ok ? one_shift : '0;
            r_two_shift  <= pitch_ok ? two_shift : '0;
            r_gate_level <= n_gate;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.active           = r_active;
    assign o_result.voice_one_target = r_one_target;
    assign o_result.voice_two_target = r_two_target;
    assign o_result.voice_one_shift  = r_one_shift;
    assign o_result.voice_two_shift  = r_two_shift;
    assign o_result.gate_level       = r_gate_level;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench of harmony_note_mapper_core: directed and random note streams.
module tb_top;

    // Register indexes past the end of the register list; writes there must be ignored.
    localparam logic [hnm_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [hnm_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
    // The one scale code with no scale of its own; it behaves as chromatic.
    localparam logic [hnm_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    // Scale degrees in semitones above the key tonic.
    localparam int MAJOR_SEMIS [7] = '{0, 2, 4, 5, 7, 9, 11};
    localparam int MINOR_SEMIS [7] = '{0, 2, 3, 5, 7, 8, 10};

    localparam int RUN_LIMIT       = 1_000_000;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_ITEMS     = 55;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_GUARD     = 20000;

    // One result transfer, laid out field by field at the port widths.
    typedef struct packed {
        logic                                active;
        logic signed [hnm_pkg::TARGET_W-1:0] voice_one_target;
        logic signed [hnm_pkg::TARGET_W-1:0] voice_two_target;
        logic signed [hnm_pkg::SHIFT_W-1:0]  voice_one_shift;
        logic signed [hnm_pkg::SHIFT_W-1:0]  voice_two_shift;
        logic [hnm_pkg::GATE_W-1:0]          gate_level;
    } t_voice_pair;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    hnm_note_if   note_ch ();
    hnm_result_if result_ch ();
    hnm_cfg_if    cfg_ch ();

    harmony_note_mapper_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_note   (note_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    // Our own copy of the register file and of the voice gate, kept in step with
    // every configuration transfer and every note transfer.
    logic                       cfg_mode      = hnm_pkg::MODE_DIATONIC;
    logic [hnm_pkg::KIND_W-1:0] cfg_kind      = hnm_pkg::KIND_CHROMATIC;
    logic [hnm_pkg::KEY_W-1:0]  cfg_key       = '0;
    int                         cfg_iv_one    = 0;
    int                         cfg_iv_two    = 0;
    logic [hnm_pkg::CONF_W-1:0] cfg_threshold = 10'd512;
    int                         gate_now      = 0;

    // Results still owed by the block, oldest first.
    t_voice_pair expected_voices [$];

    // Idling controls. The percentages set how often a side inserts a gap;
    // hold_left forces a long receiver stall and is counted down by the ready process.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;
    int stall_left  = 0;

    int fail_count      = 0;
    int note_transfers  = 0;
    int accepted_notes  = 0;
    int results_checked = 0;
    int config_writes   = 0;
    int gate_full_hits  = 0;
    int gate_zero_hits  = 0;

    // Gap length: one time in ten drawn from the long range, otherwise from the short one.
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(8, 40));
        return int'($urandom_range(1, 3));
    endfunction

    // Uniform value in lo..hi that lands on either end a quarter of the time.
    function automatic int edge_biased(input int lo, input int hi);
        int pick;
        pick = int'($urandom_range(0, 7));
        if (pick == 0)
            return lo;
        if (pick == 1)
            return hi;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int div_floor(input int v, input int d);
        int q;
        q = v / d;
        if ((v % d) < 0)
            q = q - 1;
        return q;
    endfunction

    // Diatonic target of one voice. The pitch class is snapped to the closest scale
    // degree by plain distance (no wrap at the octave), the earlier degree winning a
    // tie; the degree index is then moved by the interval and octaves are carried.
    // Scale code three falls through to the chromatic scale.
    function automatic int scale_step(input int src, input int steps);
        int degs [12];
        int n;
        int rel;
        int oct;
        int pc;
        int best;
        int d_new;
        int d_best;
        int tdeg;
        int wraps;
        n = 12;
        for (int i = 0; i < 12; i++)
            degs[i] = i;
        if (cfg_kind == hnm_pkg::KIND_MAJOR) begin
            n = 7;
            for (int i = 0; i < 7; i++)
                degs[i] = MAJOR_SEMIS[i];
        end else if (cfg_kind == hnm_pkg::KIND_MINOR) begin
            n = 7;
            for (int i = 0; i < 7; i++)
                degs[i] = MINOR_SEMIS[i];
        end
        rel  = src - int'(cfg_key);
        oct  = div_floor(rel, hnm_pkg::SEMIS_PER_OCTAVE);
        pc   = rel - oct * hnm_pkg::SEMIS_PER_OCTAVE;
        best = 0;
        for (int i = 1; i < n; i++) begin
            d_new  = (degs[i] > pc) ? degs[i] - pc : pc - degs[i];
            d_best = (degs[best] > pc) ? degs[best] - pc : pc - degs[best];
            if (d_new < d_best)
                best = i;
        end
        tdeg  = best + steps;
        wraps = div_floor(tdeg, n);
        return int'(cfg_key) + (oct + wraps) * hnm_pkg::SEMIS_PER_OCTAVE
               + degs[tdeg - wraps * n];
    endfunction

    // Works out the result of one note transfer and advances the gate.
    function automatic t_voice_pair predict_voices(input logic [hnm_pkg::NOTE_W-1:0] note,
                                                   input logic voiced,
                                                   input logic [hnm_pkg::CONF_W-1:0] conf);
        t_voice_pair r;
        int src;
        int t1;
        int t2;
        int s1;
        int s2;
        r   = '0;
        src = int'(note);
        if (!voiced || conf < cfg_threshold) begin
            // A rejected pitch lets the gate decay toward silence.
            gate_now = (gate_now > 2) ? gate_now - 2 : 0;
            if (gate_now == 0)
                gate_zero_hits++;
        end else begin
            if (cfg_mode == hnm_pkg::MODE_FIXED) begin
                t1 = src + cfg_iv_one;
                t2 = src + cfg_iv_two;
            end else begin
                t1 = scale_step(src, cfg_iv_one);
                t2 = scale_step(src, cfg_iv_two);
            end
            s1 = t1 - src;
            s2 = t2 - src;
            r.active           = 1'b1;
            r.voice_one_target = t1[hnm_pkg::TARGET_W-1:0];
            r.voice_two_target = t2[hnm_pkg::TARGET_W-1:0];
            r.voice_one_shift  = s1[hnm_pkg::SHIFT_W-1:0];
            r.voice_two_shift  = s2[hnm_pkg::SHIFT_W-1:0];
            gate_now = (gate_now + 8 > 100) ? 100 : gate_now + 8;
            if (gate_now == 100)
                gate_full_hits++;
            accepted_notes++;
        end
        r.gate_level = gate_now[hnm_pkg::GATE_W-1:0];
        return r;
    endfunction

    // Offers one note after an optional gap and waits for its transfer. The
    // expectation is formed at the transfer, under the registers then in force.
    task automatic send_note(input logic [hnm_pkg::NOTE_W-1:0] note, input logic voiced,
                             input logic [hnm_pkg::CONF_W-1:0] conf);
        int gap;
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? idle_len() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            note_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        note_ch.valid       <= 1'b1;
        note_ch.source_note <= note;
        note_ch.voiced      <= voiced;
        note_ch.confidence  <= conf;
        do @(posedge i_clk); while (note_ch.ready !== 1'b1);
        expected_voices.push_back(predict_voices(note, voiced, conf));
        note_transfers++;
    endtask

    // One register write; our copy follows it at the transfer itself.
    task automatic write_reg(input logic [hnm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [hnm_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            hnm_pkg::REG_HARMONY_MODE: begin
                cfg_mode = value[0];
            end
            hnm_pkg::REG_SCALE_KIND: begin
                cfg_kind = value[hnm_pkg::KIND_W-1:0];
            end
            hnm_pkg::REG_KEY_ROOT: begin
                cfg_key = value[hnm_pkg::KEY_W-1:0];
            end
            hnm_pkg::REG_VOICE_ONE_INTERVAL: begin
                cfg_iv_one = int'(signed'(value[hnm_pkg::INTERVAL_W-1:0]));
            end
            hnm_pkg::REG_VOICE_TWO_INTERVAL: begin
                cfg_iv_two = int'(signed'(value[hnm_pkg::INTERVAL_W-1:0]));
            end
            hnm_pkg::REG_CONFIDENCE_THRESHOLD: begin
                cfg_threshold = value;
            end
            default: ;
        endcase
        config_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stops offering notes and lets every owed result come out. Each note yields a
    // result, so an empty queue means an empty pipeline; the short pause after it
    // covers the two register stages all the same.
    task automatic wait_idle();
        int guard;
        @(negedge i_clk);
        note_ch.valid <= 1'b0;
        guard = 0;
        while (expected_voices.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_voices.size() != 0) begin
            $display("error: %0d results still owed after %0d cycles",
                     expected_voices.size(), DRAIN_GUARD);
            fail_count++;
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input t_voice_pair want,
                                   input t_voice_pair got);
        fail_count++;
        if (fail_count <= 10)
            $display({"error: %s; expected act=%0b t1=%0d t2=%0d s1=%0d s2=%0d gate=%0d,",
                      " got act=%0b t1=%0d t2=%0d s1=%0d s2=%0d gate=%0d"}, what,
                     want.active, want.voice_one_target, want.voice_two_target,
                     want.voice_one_shift, want.voice_two_shift, want.gate_level,
                     got.active, got.voice_one_target, got.voice_two_target,
                     got.voice_one_shift, got.voice_two_shift, got.gate_level);
    endtask

    // Receiver. It drops ready for random stretches while rx_idle_pct asks for it,
    // and for the whole of a forced hold-off while hold_left is counting down.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            result_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 99) < rx_idle_pct) begin
            result_ch.ready <= 1'b0;
            stall_left = idle_len() - 1;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // Result checker: every result transfer is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_voice_pair want;
        t_voice_pair got;
        if (i_rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            got.active           = result_ch.active;
            got.voice_one_target = result_ch.voice_one_target;
            got.voice_two_target = result_ch.voice_two_target;
            got.voice_one_shift  = result_ch.voice_one_shift;
            got.voice_two_shift  = result_ch.voice_two_shift;
            got.gate_level       = result_ch.gate_level;
            if (expected_voices.size() == 0) begin
                report_mismatch("result with nothing owed", '0, got);
            end else begin
                want = expected_voices.pop_front();
                results_checked++;
                if (got.active !== want.active ||
                    got.voice_one_target !== want.voice_one_target ||
                    got.voice_two_target !== want.voice_two_target ||
                    got.voice_one_shift !== want.voice_one_shift ||
                    got.voice_two_shift !== want.voice_two_shift ||
                    got.gate_level !== want.gate_level)
                    report_mismatch("result differs", want, got);
            end
        end
    end

    // Register values straight out of reset: diatonic mode on the chromatic scale,
    // both intervals zero and the threshold at one half. The first note is rejected
    // at a closed gate, so the gate floor is hit right away; the threshold itself
    // passes and one step below it does not.
    task automatic test_reset_defaults();
        send_note(7'd60, 1'b1, 10'd511);
        send_note(7'd60, 1'b1, 10'd512);
        send_note(7'd0, 1'b1, 10'd1023);
        send_note(7'd127, 1'b1, 10'd1023);
        send_note(7'd64, 1'b0, 10'd1023);
        send_note(7'd5, 1'b1, 10'd0);
    endtask

    // Fixed semitone mode with the widest intervals the register can hold, at both
    // ends of the note range; a zero threshold lets a zero confidence through.
    task automatic test_fixed_intervals();
        wait_idle();
        write_reg(hnm_pkg::REG_HARMONY_MODE, 10'(hnm_pkg::MODE_FIXED));
        write_reg(hnm_pkg::REG_VOICE_ONE_INTERVAL, 10'(15));
        write_reg(hnm_pkg::REG_VOICE_TWO_INTERVAL, 10'(-16));
        write_reg(hnm_pkg::REG_CONFIDENCE_THRESHOLD, 10'd0);
        send_note(7'd0, 1'b1, 10'd0);
        send_note(7'd127, 1'b1, 10'd1023);
        wait_idle();
        write_reg(hnm_pkg::REG_VOICE_ONE_INTERVAL, 10'(12));
        write_reg(hnm_pkg::REG_VOICE_TWO_INTERVAL, 10'(-12));
        send_note(7'd127, 1'b1, 10'd700);
        send_note(7'd0, 1'b1, 10'd700);
    endtask

    // Diatonic snapping: ties between two degrees, pitch class eleven in the minor
    // scale (it snaps down, not across the octave), the unused scale code, keys
    // past eleven, and writes to indexes past the register list.
    task automatic test_scale_snapping();
        wait_idle();
        write_reg(hnm_pkg::REG_HARMONY_MODE, 10'(hnm_pkg::MODE_DIATONIC));
        write_reg(hnm_pkg::REG_SCALE_KIND, 10'(hnm_pkg::KIND_MAJOR));
        write_reg(hnm_pkg::REG_KEY_ROOT, 10'd0);
        write_reg(hnm_pkg::REG_VOICE_ONE_INTERVAL, 10'(1));
        write_reg(hnm_pkg::REG_VOICE_TWO_INTERVAL, 10'(-1));
        write_reg(hnm_pkg::REG_CONFIDENCE_THRESHOLD, 10'd1023);
        send_note(7'd61, 1'b1, 10'd1023);
        send_note(7'd66, 1'b1, 10'd1023);
        send_note(7'd71, 1'b1, 10'd1023);
        send_note(7'd60, 1'b1, 10'd1022);
        wait_idle();
        write_reg(hnm_pkg::REG_SCALE_KIND, 10'(hnm_pkg::KIND_MINOR));
        write_reg(hnm_pkg::REG_VOICE_ONE_INTERVAL, 10'(7));
        write_reg(hnm_pkg::REG_VOICE_TWO_INTERVAL, 10'(-7));
        send_note(7'd11, 1'b1, 10'd1023);
        send_note(7'd4, 1'b1, 10'd1023);
        send_note(7'd8, 1'b1, 10'd1023);
        wait_idle();
        write_reg(hnm_pkg::REG_SCALE_KIND, 10'(KIND_SPARE));
        write_reg(hnm_pkg::REG_KEY_ROOT, 10'd15);
        write_reg(hnm_pkg::REG_VOICE_ONE_INTERVAL, 10'(15));
        write_reg(hnm_pkg::REG_VOICE_TWO_INTERVAL, 10'(-16));
        write_reg(REG_SPARE_LO, 10'h3FF);
        write_reg(REG_SPARE_HI, 10'h000);
        send_note(7'd0, 1'b1, 10'd1023);
        send_note(7'd127, 1'b1, 10'd1023);
        wait_idle();
        write_reg(hnm_pkg::REG_SCALE_KIND, 10'(hnm_pkg::KIND_MINOR));
        write_reg(hnm_pkg::REG_KEY_ROOT, 10'd11);
        write_reg(hnm_pkg::REG_VOICE_ONE_INTERVAL, 10'(3));
        write_reg(hnm_pkg::REG_VOICE_TWO_INTERVAL, 10'(-12));
        send_note(7'd127, 1'b1, 10'd1023);
        send_note(7'd0, 1'b1, 10'd1023);
    endtask

    // The receiver holds off for a long stretch while notes keep coming back to back,
    // so the pipeline fills and the note channel must stall without losing anything.
    task automatic test_output_stall();
        int k;
        wait_idle();
        write_reg(hnm_pkg::REG_CONFIDENCE_THRESHOLD, 10'd300);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(posedge i_clk);
        hold_left = HOLD_OFF_CYCLES;
        for (k = 0; k < 20; k++)
            send_note(7'($urandom), 1'($urandom), 10'($urandom));
    endtask

    // Random phases. Each phase writes every register, biased toward the extremes,
    // picks how busy each side is and how often the pitch is voiced, then streams
    // notes whose confidence is either anywhere or close to the threshold.
    task automatic test_random_phases();
        int idle_pcts [4];
        int voiced_pcts [3];
        int p;
        int k;
        int voiced_pct;
        int conf;
        idle_pcts   = '{0, 10, 30, 60};
        voiced_pcts = '{95, 70, 20};
        for (p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            write_reg(hnm_pkg::REG_HARMONY_MODE, {9'($urandom), 1'($urandom)});
            write_reg(hnm_pkg::REG_SCALE_KIND, {8'($urandom), 2'($urandom)});
            write_reg(hnm_pkg::REG_KEY_ROOT, {6'($urandom), 4'(edge_biased(0, 15))});
            write_reg(hnm_pkg::REG_VOICE_ONE_INTERVAL, 10'(edge_biased(-16, 15)));
            write_reg(hnm_pkg::REG_VOICE_TWO_INTERVAL, 10'(edge_biased(-16, 15)));
            write_reg(hnm_pkg::REG_CONFIDENCE_THRESHOLD, 10'(edge_biased(0, 1023)));
            tx_idle_pct = idle_pcts[$urandom_range(0, 3)];
            rx_idle_pct = idle_pcts[$urandom_range(0, 3)];
            voiced_pct  = voiced_pcts[$urandom_range(0, 2)];
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 1) == 0) begin
                    conf = edge_biased(0, 1023);
                end else begin
                    conf = int'(cfg_threshold) + int'($urandom_range(0, 8)) - 4;
                    conf = (conf < 0) ? 0 : (conf > 1023) ? 1023 : conf;
                end
                send_note(7'(edge_biased(0, 127)),
                          ($urandom_range(0, 99) < voiced_pct), 10'(conf));
            end
        end
    endtask

    initial begin
        note_ch.valid       = 1'b0;
        note_ch.source_note = '0;
        note_ch.voiced      = 1'b0;
        note_ch.confidence  = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        result_ch.ready     = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_fixed_intervals();
        test_scale_snapping();
        test_output_stall();
        test_random_phases();

        // Let the last results out, then allow a few more cycles for stray ones.
        wait_idle();
        rx_idle_pct = 0;
        repeat (10) @(posedge i_clk);
        if (expected_voices.size() != 0) begin
            $display("error: %0d results never arrived", expected_voices.size());
            fail_count++;
        end

        $display("Covered %0d note transfers (%0d accepted pitches) and %0d register writes.",
                 note_transfers, accepted_notes, config_writes);
        $display("Checked %0d results; gate at full level %0d times, at zero %0d times.",
                 results_checked, gate_full_hits, gate_zero_hits);
        if (fail_count == 0)
            $display("PASS harmony_note_mapper_core");
        else
            $display("FAIL harmony_note_mapper_core");
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("error: run did not finish in time");
        $display("FAIL harmony_note_mapper_core");
        $finish;
    end

endmodule
